/* hw/rtl/ctk_pkg.sv */
// Package with the shared types and constants of the cosine top-k retrieval block.
`default_nettype none
package ctk_pkg;
    localparam int DIM_DEF        = 64;
    localparam int POOL_DEPTH_DEF = 4096;
    localparam int K_MAX_DEF      = 16;
    localparam int SCORE_W        = 17;
    localparam int ACC_W          = 40;
    localparam logic [16:0] SCORE_MAX = 17'd131071;
    localparam logic [0:0] CFG_TOP_K     = 1'b0;
    localparam logic [0:0] CFG_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] value;
        logic               last_element;
        logic               last_vector;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  rank;
        logic [11:0] memory_index;
        logic [16:0] score;
        logic        last;
    } out_word_t;
endpackage
`default_nettype wire

/* hw/rtl/ctk_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module ctk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/ctk_sim_unit.sv */
// Iterative similarity and score unit: bit-serial root search and boost division.
`default_nettype none
module ctk_sim_unit import ctk_pkg::*; #(
    parameter int IDX_W = 12
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic               zero_sim,
    input  wire logic [ACC_W-1:0]   dot,
    input  wire logic [ACC_W-1:0]   qn,
    input  wire logic [ACC_W-1:0]   mn,
    input  wire logic [IDX_W-1:0]   index,
    input  wire logic [12:0]        pool,
    output logic                    done,
    output logic [SCORE_W-1:0]      score
);
    // Phases: multiply dot^2 and qn*mn in 16-bit digit steps, search S bit by bit
    // comparing prod*mid^2 with dot^2*2^32, then divide S*index by 10*pool.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_MUL = 6'b000010, S_SRCH = 6'b000100,
        S_SQ = 6'b001000, S_DIV = 6'b010000, S_DONE = 6'b100000
    } st_t;
    st_t st_reg, st_next;
    logic [79:0] rhs_reg, prod_reg;
    logic [79:0] acc1_reg, acc2_reg;
    logic [2:0]  dig_reg;
    logic [16:0] s_reg;
    logic [4:0]  bit_reg;
    logic [33:0] msq_reg;
    logic [5:0]  sq_reg;
    logic [113:0] cmp_reg;
    logic [IDX_W+16:0] num_reg;
    logic [IDX_W+16:0] quo_reg;
    logic [IDX_W+17:0] rem_reg;
    logic [6:0]  dbit_reg;
    logic        zero_sim_q;
    logic [16:0] trial;
    logic [15:0] dd, qd;
    logic [16:0] den;
    logic [IDX_W+17:0] rsh;
    logic [17:0] sum;
    assign trial = s_reg | (17'd1 << bit_reg);
    assign dd = (dig_reg == 3'd0) ? dot[15:0] :
                (dig_reg == 3'd1) ? dot[31:16] : 16'(dot[ACC_W-1:32]);
    assign qd = (dig_reg == 3'd0) ? qn[15:0] :
                (dig_reg == 3'd1) ? qn[31:16] : 16'(qn[ACC_W-1:32]);
    assign den = (pool == 13'd0) ? 17'd10 : ({4'd0, pool} * 17'd10);
    assign rsh = {rem_reg[IDX_W+16:0], num_reg[IDX_W+16]};
    assign sum = {1'b0, s_reg} + {1'b0, quo_reg[16:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (start) st_next = zero_sim ? S_DIV : S_MUL;
            S_MUL:  if (dig_reg == 3'd2) st_next = S_SQ;
            S_SQ:   if (sq_reg == 6'd33) st_next = S_SRCH;
            S_SRCH: st_next = (bit_reg == 5'd0) ? S_DIV : S_SQ;
            S_DIV:  if (dbit_reg == 7'd0) st_next = S_DONE;
            S_DONE: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            S_IDLE: begin
                acc1_reg <= '0; acc2_reg <= '0; dig_reg <= '0;
                s_reg <= '0; bit_reg <= 5'd16; sq_reg <= '0;
                msq_reg <= 34'd65536 * 34'd65536; cmp_reg <= '0;
                dbit_reg <= 7'(IDX_W + 17); rem_reg <= '0; quo_reg <= '0;
            end
            S_MUL: begin
                acc1_reg <= acc1_reg + ((80'(dot) * 80'(dd)) << (dig_reg * 16));
                acc2_reg <= acc2_reg + ((80'(mn) * 80'(qd)) << (dig_reg * 16));
                dig_reg <= dig_reg + 3'd1;
                if (dig_reg == 3'd2) begin
                    rhs_reg  <= acc1_reg + ((80'(dot) * 80'(dd)) << 32);
                    prod_reg <= acc2_reg + ((80'(mn) * 80'(qd)) << 32);
                    msq_reg  <= 34'(trial) * 34'(trial);
                end
            end
            S_SQ: begin
                // shift-add prod * trial^2, one bit per cycle
                if (msq_reg[sq_reg]) cmp_reg <= cmp_reg + (114'(prod_reg) << sq_reg);
                sq_reg <= sq_reg + 6'd1;
            end
            S_SRCH: begin
                if (cmp_reg <= (114'(rhs_reg) << 32)) s_reg <= trial;
                if (bit_reg != 5'd0) begin
                    bit_reg <= bit_reg - 5'd1;
                    msq_reg <= 34'((cmp_reg <= (114'(rhs_reg) << 32) ? trial : s_reg)
                               | (17'd1 << (bit_reg - 5'd1)))
                             * 34'((cmp_reg <= (114'(rhs_reg) << 32) ? trial : s_reg)
                               | (17'd1 << (bit_reg - 5'd1)));
                end
                sq_reg <= '0; cmp_reg <= '0;
                num_reg <= '0;
            end
            S_DIV: begin
                if (dbit_reg == 7'(IDX_W + 17)) begin
                    num_reg <= (IDX_W+17)'(s_reg) * (IDX_W+17)'(index);
                    dbit_reg <= dbit_reg - 7'd1;
                end else begin
                    if (rsh >= (IDX_W+18)'(den)) begin
                        rem_reg <= rsh - (IDX_W+18)'(den);
                        quo_reg <= {quo_reg[IDX_W+15:0], 1'b1};
                    end else begin
                        rem_reg <= rsh;
                        quo_reg <= {quo_reg[IDX_W+15:0], 1'b0};
                    end
                    num_reg <= {num_reg[IDX_W+15:0], 1'b0};
                    dbit_reg <= dbit_reg - 7'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && start) zero_sim_q <= zero_sim;
    end

    assign done = (st_reg == S_DONE);
    assign score = (zero_sim_q || s_reg == 17'd0) ? 17'd0 :
                   ((quo_reg[IDX_W+16:17] != '0) || sum[17] || sum[16:0] > SCORE_MAX)
                   ? SCORE_MAX : sum[16:0];
endmodule
`default_nettype wire

/* hw/rtl/ctk_list.sv */
// Sorted best-score list with one-entry-per-cycle insertion and readout.
`default_nettype none
module ctk_list import ctk_pkg::*; #(
    parameter int K_MAX = 16,
    parameter int IDX_W = 12
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     ins,
    input  wire logic [SCORE_W-1:0]       ins_score,
    input  wire logic [IDX_W-1:0]         ins_index,
    input  wire logic                     clr,
    input  wire logic [$clog2(K_MAX+1)-1:0] rd_pos,
    output logic [SCORE_W-1:0]            rd_score,
    output logic [IDX_W-1:0]              rd_index,
    output logic [$clog2(K_MAX+1)-1:0]    held
);
    localparam int CW = $clog2(K_MAX + 1);
    logic [SCORE_W-1:0] sc_reg [K_MAX];
    logic [IDX_W-1:0]   ix_reg [K_MAX];
    logic [CW-1:0]      held_reg;
    logic [K_MAX-1:0]   beat;
    // Entry i is beaten by the new item when it is not strictly better.
    always_comb begin
        for (int i = 0; i < K_MAX; i++) begin
            beat[i] = (i >= held_reg) || (sc_reg[i] < ins_score) ||
                      (sc_reg[i] == ins_score && ix_reg[i] >= ins_index);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            held_reg <= '0;
        end else if (ins && held_reg < CW'(K_MAX)) begin
            held_reg <= held_reg + CW'(1);
        end
    end
    always_ff @(posedge aclk) begin
        if (ins) begin
            for (int i = 0; i < K_MAX; i++) begin
                if (beat[i]) begin
                    if (i == 0 || !beat[(i == 0) ? 0 : i-1]) begin
                        sc_reg[i] <= ins_score; ix_reg[i] <= ins_index;
                    end else begin
                        sc_reg[i] <= sc_reg[(i == 0) ? 0 : i-1];
                        ix_reg[i] <= ix_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
    end
    assign rd_score = sc_reg[rd_pos[$clog2(K_MAX > 1 ? K_MAX : 2)-1:0]];
    assign rd_index = ix_reg[rd_pos[$clog2(K_MAX > 1 ? K_MAX : 2)-1:0]];
    assign held = held_reg;
endmodule
`default_nettype wire

/* hw/rtl/cosine_top_k_retrieval.sv */
// Top level of the cosine top-k retrieval block.
// Usage: load a query with words of cmd 0 (last_element ends it), then stream
// memory vectors with cmd 1. A query word is written to the query RAM, and a memory
// word is taken in T_IN and accumulated in T_ACC, as query elements are read from
// a registered RAM. The word ending a memory vector then passes T_SIM, starting the
// shared iterative unit, which forms the similarity in three 16-bit multiply
// digits, 17 root-search bits of shift-add and one compare each, and a boost
// division, going straight to the division when the similarity is zero. The
// sorted list takes the entry in the same cycle. s_ready is low meanwhile.
// After last_vector the block emits min(top_k, held) result words best first,
// one per cycle while m_ready is high; a stalled receiver holds the word and
// the block. The run then clears the list and vector count. Reset
// (synchronous, aresetn low) returns top_k to 4, pool_size to 4096 and empties
// the list; the query RAM keeps no reset.
// Configuration words are accepted at any time with cfg_ready high.
`default_nettype none
module cosine_top_k_retrieval import ctk_pkg::*; #(
    parameter int DIM        = DIM_DEF,
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int K_MAX      = K_MAX_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int PW = $clog2(DIM + 1);
    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(K_MAX + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    typedef enum logic [4:0] {
        T_IN = 5'b00001, T_ACC = 5'b00010, T_SIM = 5'b00100,
        T_OUT = 5'b01000, T_INS = 5'b10000
    } top_st_t;
    top_st_t st_reg;

    logic [4:0]  top_k_reg;
    logic [12:0] pool_reg;
    logic [PW-1:0] pos_reg, qlen_reg;
    logic signed [ACC_W-1:0] dot_reg;
    logic [ACC_W-1:0] qn_reg, mn_reg;
    logic [IW-1:0] cnt_reg;
    in_word_t w_reg;
    logic [CW-1:0] opos_reg, ocnt_reg;
    logic [15:0] q_rd;
    logic q_we;
    logic sim_start, sim_done;
    logic [SCORE_W-1:0] sim_score, rd_score;
    logic [IW-1:0] rd_index;
    logic [CW-1:0] held;
    logic [LW-1:0] held_after, top_lim;
    logic list_clr;
    logic acc_hit;
    logic signed [31:0] pq, pqq, pmm;
    logic acc_en;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_k_reg <= 5'd4; pool_reg <= 13'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TOP_K:     top_k_reg <= cfg_data[4:0];
                CFG_POOL_SIZE: pool_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign s_ready = (st_reg == T_IN);
    assign q_we = s_valid && s_ready && !s_data.cmd && pos_reg < PW'(DIM);

    ctk_ram #(.WIDTH(16), .DEPTH(DIM)) u_qram (
        .aclk(aclk), .we(q_we), .addr(pos_reg[AW-1:0]),
        .wdata(s_data.value), .rdata(q_rd)
    );

    assign acc_hit = pos_reg < qlen_reg;
    assign pq  = $signed(q_rd) * w_reg.value;
    assign pqq = $signed(q_rd) * $signed(q_rd);
    assign pmm = w_reg.value * w_reg.value;
    assign acc_en = (st_reg == T_ACC) && acc_hit;
    assign sim_start = (st_reg == T_SIM);

    ctk_sim_unit #(.IDX_W(IW)) u_sim (
        .aclk(aclk), .aresetn(aresetn), .start(sim_start),
        .zero_sim(qlen_reg == '0 || dot_reg <= 0 || qn_reg == '0 || mn_reg == '0),
        .dot(dot_reg), .qn(qn_reg), .mn(mn_reg), .index(cnt_reg), .pool(pool_reg),
        .done(sim_done), .score(sim_score)
    );

    ctk_list #(.K_MAX(K_MAX), .IDX_W(IW)) u_list (
        .aclk(aclk), .aresetn(aresetn), .ins(sim_done), .ins_score(sim_score),
        .ins_index(cnt_reg), .clr(list_clr), .rd_pos(opos_reg),
        .rd_score(rd_score), .rd_index(rd_index), .held(held)
    );
    assign list_clr = (st_reg == T_OUT) && (opos_reg >= ocnt_reg);

    assign held_after = LW'(held) + LW'(held < CW'(K_MAX));
    assign top_lim = (LW'(top_k_reg) < held_after) ? LW'(top_k_reg) : held_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= T_IN; pos_reg <= '0; qlen_reg <= '0; cnt_reg <= '0;
            dot_reg <= '0; qn_reg <= '0; mn_reg <= '0; m_valid <= 1'b0;
            opos_reg <= '0; ocnt_reg <= '0;
        end else begin
            case (st_reg)
                T_IN: if (s_valid) begin
                    w_reg <= s_data;
                    if (!s_data.cmd) begin
                        if (s_data.last_element) begin
                            qlen_reg <= (pos_reg < PW'(DIM)) ? pos_reg + PW'(1) : PW'(DIM);
                            pos_reg <= '0;
                            dot_reg <= '0; qn_reg <= '0; mn_reg <= '0;
                        end else if (pos_reg < PW'(DIM)) begin
                            pos_reg <= pos_reg + PW'(1);
                        end
                    end else begin
                        st_reg <= T_ACC;
                    end
                end
                T_ACC: begin
                    if (acc_en) begin
                        dot_reg <= dot_reg + ACC_W'(pq);
                        qn_reg  <= qn_reg + ACC_W'(unsigned'(pqq));
                        mn_reg  <= mn_reg + ACC_W'(unsigned'(pmm));
                    end
                    if (w_reg.last_element || w_reg.last_vector) begin
                        st_reg <= T_SIM;
                    end else begin
                        if (pos_reg < PW'(DIM)) pos_reg <= pos_reg + PW'(1);
                        st_reg <= T_IN;
                    end
                end
                T_SIM: st_reg <= T_INS;
                T_INS: if (sim_done) begin
                    cnt_reg <= (cnt_reg == IW'(POOL_DEPTH - 1)) ? '0 : cnt_reg + IW'(1);
                    pos_reg <= '0;
                    dot_reg <= '0; qn_reg <= '0; mn_reg <= '0;
                    if (w_reg.last_vector) begin
                        st_reg <= T_OUT; opos_reg <= '0;
                        ocnt_reg <= CW'(top_lim);
                    end else begin
                        st_reg <= T_IN;
                    end
                end
                T_OUT: begin
                    if (!m_valid || m_ready) begin
                        if (opos_reg < ocnt_reg) begin
                            m_valid <= 1'b1;
                            m_data.rank <= 4'(opos_reg);
                            m_data.memory_index <= 12'(rd_index);
                            m_data.score <= rd_score;
                            m_data.last <= (opos_reg + CW'(1) == ocnt_reg);
                            opos_reg <= opos_reg + CW'(1);
                        end else begin
                            m_valid <= 1'b0;
                        end
                    end
                    if (list_clr && (!m_valid || m_ready)) begin
                        cnt_reg <= '0; st_reg <= T_IN;
                    end
                end
                default: st_reg <= T_IN;
            endcase
        end
    end

    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == T_SIM) |-> !s_ready) else $error("input taken while busy");
    a_held_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        held <= CW'(K_MAX)) else $error("list overfilled");
    a_out_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && st_reg != T_OUT) |-> 1'b0) else $error("result outside readout");
endmodule
`default_nettype wire
